@@ design/tuzs_pkg.sv @@
// Types and constants shared by the time-of-use zone select block.
// No dependencies; every other file in this folder refers to it by scoped names.

package tuzs_pkg;

	localparam int REG_W = 64;
	localparam int ADDR_W = 5;
	localparam logic [7:0] DEFAULT_TARIFF = 8'h01;

	typedef enum logic [1:0] {
		REG_ZONE_COUNT    = 2'd0,
		REG_START_HOURS   = 2'd1,
		REG_START_MINUTES = 2'd2,
		REG_TARIFF_MAP    = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [5:0] hour_bcd;
		logic [6:0] minute_bcd;
	} tod_word_t;

	typedef struct packed {
		logic [7:0] tariff;
		logic       zone_changed;
		logic       used_default;
	} zone_word_t;

	typedef struct packed {
		logic [3:0]       zone_count;
		logic [REG_W-1:0] start_hours;
		logic [REG_W-1:0] start_minutes;
		logic [REG_W-1:0] tariff_map;
	} cfg_t;

endpackage

@@ design/time_of_use_zone_select_core.sv @@
// Top level of the time-of-use zone selector: input register, select logic, result register.
// Depends on tuzs_pkg, tuzs_regs and tuzs_select.
//
//   channel  | handshake                    | word
//   ---------+------------------------------+-------------------------------------
//   tod      | tod_valid / tod_stall        | hour_bcd, minute_bcd
//   zone     | zone_valid / zone_stall      | tariff, zone_changed, used_default
//   config   | psel, penable, pwrite, pready| 64-bit registers at byte address 8*i
//
// One word per cycle while zone_stall is low; words pass the input, then the result register.
// The previous-tariff register closes a loop through the select logic.
// Reset clears configuration, valid flags and the previous tariff to zero.
// A stalled result holds; the input register keeps accepting while the result register drains.

module time_of_use_zone_select_core #(
	parameter int MAX_ZONES = 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        tod_valid,
	output logic                        tod_stall,
	input  tuzs_pkg::tod_word_t         tod,
	output logic                        zone_valid,
	input  logic                        zone_stall,
	output tuzs_pkg::zone_word_t        zone,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [tuzs_pkg::ADDR_W-1:0] paddr,
	input  logic [tuzs_pkg::REG_W-1:0]  pwdata,
	output logic [tuzs_pkg::REG_W-1:0]  prdata,
	output logic                        pready
);

	tuzs_pkg::cfg_t       cfg;
	tuzs_pkg::tod_word_t  tod_s1;
	logic                 valid_s1;
	tuzs_pkg::zone_word_t zone_s2;
	logic                 valid_s2;
	tuzs_pkg::zone_word_t sel_result;
	logic [7:0]           prev_tariff_q;
	logic                 adv_s2;
	logic                 load_s1;

	tuzs_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	tuzs_select #(
		.MAX_ZONES (MAX_ZONES)
	) u_select (
		.cfg         (cfg),
		.tod         (tod_s1),
		.prev_tariff (prev_tariff_q),
		.result      (sel_result)
	);

	assign adv_s2    = !valid_s2 || !zone_stall;
	assign load_s1   = !valid_s1 || adv_s2;
	assign tod_stall = !load_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_s1) begin
			valid_s1 <= tod_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1 && tod_valid) begin
			tod_s1 <= tod;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2      <= 1'b0;
			prev_tariff_q <= '0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
			if (valid_s1) begin
				prev_tariff_q <= sel_result.tariff;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			zone_s2 <= sel_result;
		end
	end

	assign zone_valid = valid_s2;
	assign zone       = zone_s2;

`ifndef SYNTHESIS
	a_default_tariff: assert property (@(posedge clk) disable iff (!arst_n)
		(zone_valid && zone.used_default) |-> (zone.tariff == tuzs_pkg::DEFAULT_TARIFF))
		else $error("default result carries a non-default tariff");

	a_prev_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && adv_s2) |=> (prev_tariff_q == zone.tariff && zone_valid))
		else $error("previous tariff does not follow the last result");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		tod_stall |-> (valid_s1 && valid_s2 && zone_stall))
		else $error("input stalled with room in the pipeline");

	a_zero_count: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && adv_s2 && cfg.zone_count == 4'd0) |=> zone.used_default)
		else $error("zero zone count did not select the default");
`endif

endmodule

@@ design/tuzs_regs.sv @@
// Configuration register file with an APB-style write/read port.
// Depends on tuzs_pkg for the register index codes and the cfg_t bundle.

module tuzs_regs (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [tuzs_pkg::ADDR_W-1:0] paddr,
	input  logic [tuzs_pkg::REG_W-1:0]  pwdata,
	output logic [tuzs_pkg::REG_W-1:0]  prdata,
	output logic                      pready,
	output tuzs_pkg::cfg_t            cfg
);

	tuzs_pkg::cfg_t   cfg_q;
	tuzs_pkg::reg_idx_t idx;
	logic             wr_en;

	assign idx    = tuzs_pkg::reg_idx_t'(paddr[4:3]);
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			case (idx)
				tuzs_pkg::REG_ZONE_COUNT:    cfg_q.zone_count    <= pwdata[3:0];
				tuzs_pkg::REG_START_HOURS:   cfg_q.start_hours   <= pwdata;
				tuzs_pkg::REG_START_MINUTES: cfg_q.start_minutes <= pwdata;
				tuzs_pkg::REG_TARIFF_MAP:    cfg_q.tariff_map    <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			tuzs_pkg::REG_ZONE_COUNT:    prdata = {60'd0, cfg_q.zone_count};
			tuzs_pkg::REG_START_HOURS:   prdata = cfg_q.start_hours;
			tuzs_pkg::REG_START_MINUTES: prdata = cfg_q.start_minutes;
			tuzs_pkg::REG_TARIFF_MAP:    prdata = cfg_q.tariff_map;
			default:                     prdata = '0;
		endcase
	end

endmodule

@@ design/tuzs_select.sv @@
// Zone selection: parallel start-time compares, first-match pick, tariff lookup.
// Depends on tuzs_pkg for the word types, cfg_t and the default tariff.

module tuzs_select #(
	parameter int MAX_ZONES = 8
) (
	input  tuzs_pkg::cfg_t      cfg,
	input  tuzs_pkg::tod_word_t tod,
	input  logic [7:0]          prev_tariff,
	output tuzs_pkg::zone_word_t result
);

	localparam int CW = $clog2(MAX_ZONES + 1);

	logic [CW-1:0]        count;
	logic [MAX_ZONES-1:0] after_now;
	logic [CW-1:0]        first_k;
	logic                 found;
	logic [CW-1:0]        slot;
	logic [2:0]           map_idx;
	logic [7:0]           map_tariff;
	logic [7:0]           tariff;
	logic [7:0]           hour;
	logic [7:0]           minute;

	assign count = (cfg.zone_count > 4'(MAX_ZONES)) ? CW'(MAX_ZONES) : CW'(cfg.zone_count);
	assign hour   = {2'd0, tod.hour_bcd};
	assign minute = {1'd0, tod.minute_bcd};

	always_comb begin
		for (int k = 0; k < MAX_ZONES; k++) begin
			after_now[k] = (CW'(k) < count) &&
				((cfg.start_hours[k*8 +: 8] > hour) ||
				 ((cfg.start_hours[k*8 +: 8] == hour) &&
				  (cfg.start_minutes[k*8 +: 8] > minute)));
		end
	end

	always_comb begin
		first_k = '0;
		found   = 1'b0;
		for (int k = MAX_ZONES - 1; k >= 0; k--) begin
			if (after_now[k]) begin
				first_k = CW'(k);
				found   = 1'b1;
			end
		end
	end

	assign slot       = (found && (first_k != '0)) ? first_k : count;
	assign map_idx    = 3'(slot - CW'(1));
	assign map_tariff = cfg.tariff_map[map_idx*8 +: 8];
	assign tariff     = (count == '0) ? tuzs_pkg::DEFAULT_TARIFF : map_tariff;

	assign result.tariff       = tariff;
	assign result.zone_changed = (tariff != prev_tariff);
	assign result.used_default = (count == '0);

endmodule
